// ===== rtl/core/bksk_pkg.sv =====
// Shared constants and controller/datapath interface types for the score keeper.
`timescale 1ns / 1ps
`default_nettype none
package bksk_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int TAG_BITS    = 16;

  localparam int IDX_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int TAG_W    = (TAG_BITS < 16) ? TAG_BITS : 16;
  localparam int CFG_W    = 5;
  localparam int SCORE_W  = 32;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 96;
  localparam int CAP_RST  = (TABLE_DEPTH < 16) ? TABLE_DEPTH : 16;

  localparam logic SCAN_INSERT = 1'b0;  // worst + first equal
  localparam logic SCAN_REPORT = 1'b1;  // worst + best

  typedef struct packed {
    logic load_item;
    logic scan_start;
    logic scan_mode;
    logic scan_run;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/bksk_ctrl.sv =====
// Sequencer for one candidate: insert scan, table update, report scan, result load.
`timescale 1ns / 1ps
`default_nettype none
module bksk_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire bksk_pkg::status_t status,
  output bksk_pkg::cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN1  = 3'd1;
  localparam logic [2:0] ST_COMMIT = 3'd2;
  localparam logic [2:0] ST_SCAN2  = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.scan_mode  = bksk_pkg::SCAN_INSERT;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item  = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN1;
        end
      end
      ST_SCAN1: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit     = 1'b1;
        cmd.scan_start = 1'b1;
        cmd.scan_mode  = bksk_pkg::SCAN_REPORT;
        state_next     = ST_SCAN2;
      end
      ST_SCAN2: begin
        cmd.scan_mode = bksk_pkg::SCAN_REPORT;
        cmd.scan_run  = 1'b1;
        if (status.scan_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.scan_mode = bksk_pkg::SCAN_REPORT;
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/bksk_datapath.sv =====
// Entry table, scan comparators, capacity/count registers and result register.
`timescale 1ns / 1ps
`default_nettype none
module bksk_datapath (
  input  wire                              clk,
  input  wire                              rst,
  input  wire bksk_pkg::cmd_t              cmd,
  output bksk_pkg::status_t                status,
  input  wire [bksk_pkg::IN_W-1:0]         in_data,
  input  wire                              cfg_valid,
  input  wire [bksk_pkg::CFG_W-1:0]        cfg_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [bksk_pkg::OUT_W-1:0]       out_data
);

  localparam int IDX_W   = bksk_pkg::IDX_W;
  localparam int CNT_W   = bksk_pkg::CNT_W;
  localparam int TAG_W   = bksk_pkg::TAG_W;
  localparam int SCORE_W = bksk_pkg::SCORE_W;
  localparam int DEPTH   = bksk_pkg::TABLE_DEPTH;

  logic [SCORE_W-1:0] scores [DEPTH];
  logic [TAG_W-1:0]   tags   [DEPTH];

  logic [CNT_W-1:0]   capacity;
  logic [CNT_W-1:0]   valid_count;
  logic [CNT_W-1:0]   cfg_cap;

  logic [SCORE_W-1:0] cand_score;
  logic [TAG_W-1:0]   cand_tag;

  logic               mode;
  logic [CNT_W-1:0]   scan_addr;
  logic               rd_pend;
  logic [IDX_W-1:0]   rd_idx;
  logic [SCORE_W-1:0] rd_score;
  logic [TAG_W-1:0]   rd_tag;
  logic [CNT_W-1:0]   scan_lim;
  logic               issue;

  logic [SCORE_W-1:0] worst_score;
  logic [IDX_W-1:0]   worst_idx;
  logic               eq_found;
  logic [IDX_W-1:0]   eq_idx;
  logic [SCORE_W-1:0] best_score;
  logic [TAG_W-1:0]   best_tag;

  logic               res_acc;
  logic [IDX_W-1:0]   res_pos;
  logic               res_eq;

  logic [CNT_W-1:0]   n_cur;
  logic               full_cur;
  logic               acc;
  logic               eq;
  logic [IDX_W-1:0]   pos;
  logic [CNT_W-1:0]   n_new;
  logic               full_new;

  // Clamp the written capacity to 1..depth.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_cap = CNT_W'(1);
    end else if (32'(cfg_data) > 32'(DEPTH)) begin
      cfg_cap = CNT_W'(DEPTH);
    end else begin
      cfg_cap = CNT_W'(cfg_data);
    end
  end

  assign n_cur    = (valid_count > capacity) ? capacity : valid_count;
  assign full_cur = (n_cur == capacity);
  assign scan_lim = (mode == bksk_pkg::SCAN_INSERT) ? n_cur : valid_count;
  assign issue    = cmd.scan_run && (scan_addr < scan_lim);

  assign status.scan_done = (scan_addr >= scan_lim) && !rd_pend;
  assign status.out_free  = !out_valid || out_ready;

  // Insert decision from the first scan.
  always_comb begin
    acc = !full_cur || !(cand_score > worst_score);
    eq  = acc && eq_found;
    if (eq) begin
      pos = eq_idx;
    end else if (full_cur) begin
      pos = worst_idx;
    end else begin
      pos = n_cur[IDX_W-1:0];
    end
    n_new = (acc && !eq && !full_cur) ? n_cur + CNT_W'(1) : n_cur;
  end

  assign full_new = (valid_count == capacity);

  // Table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit && acc) begin
      scores[pos] <= cand_score;
      tags[pos]   <= cand_tag;
    end
    if (issue) begin
      rd_score <= scores[scan_addr[IDX_W-1:0]];
      rd_tag   <= tags[scan_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CNT_W'(bksk_pkg::CAP_RST);
      valid_count <= '0;
      rd_pend     <= 1'b0;
      scan_addr   <= '0;
      mode        <= bksk_pkg::SCAN_INSERT;
      eq_found    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_cap;
        if (valid_count > cfg_cap) begin
          valid_count <= cfg_cap;
        end
      end
      if (cmd.scan_start) begin
        scan_addr <= '0;
        rd_pend   <= 1'b0;
        mode      <= cmd.scan_mode;
        eq_found  <= 1'b0;
      end else if (cmd.scan_run) begin
        rd_pend <= issue;
        if (issue) begin
          scan_addr <= scan_addr + CNT_W'(1);
        end
        if (rd_pend && mode == bksk_pkg::SCAN_INSERT && !eq_found &&
            rd_score == cand_score) begin
          eq_found <= 1'b1;
        end
      end
      if (cmd.commit) begin
        valid_count <= n_new;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item, scan comparator, decision and result registers; payload only, no reset.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cand_score <= in_data[SCORE_W-1:0];
      cand_tag   <= in_data[SCORE_W +: TAG_W];
    end
    if (issue) begin
      rd_idx <= scan_addr[IDX_W-1:0];
    end
    if (cmd.scan_run && rd_pend) begin
      if (rd_idx == '0 || rd_score > worst_score) begin
        worst_score <= rd_score;
        worst_idx   <= rd_idx;
      end
      if (mode == bksk_pkg::SCAN_INSERT) begin
        if (!eq_found && rd_score == cand_score) begin
          eq_idx <= rd_idx;
        end
      end else if (rd_idx == '0 || rd_score < best_score) begin
        best_score <= rd_score;
        best_tag   <= rd_tag;
      end
    end
    if (cmd.commit) begin
      res_acc <= acc;
      res_pos <= pos;
      res_eq  <= eq;
    end
    if (cmd.load_out) begin
      out_data[0]     <= res_acc;
      out_data[4:1]   <= res_acc ? 4'(res_pos) : 4'd0;
      out_data[5]     <= res_eq;
      out_data[10:6]  <= 5'(valid_count);
      out_data[11]    <= full_new;
      out_data[43:12] <= full_new ? worst_score : '0;
      out_data[75:44] <= (valid_count != '0) ? best_score : '0;
      out_data[91:76] <= (valid_count != '0) ? 16'(best_tag) : 16'd0;
      out_data[95:92] <= 4'd0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/best_k_score_keeper_unit.sv =====
// Top level of the best-K score keeper: stream ports, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Keeps the lowest-scored candidates (score, tag) up to the configured capacity
// in a table of 16 entries. Each input transaction yields one result transaction
// telling whether and where the candidate was stored, the entry count, the worst
// score once the table is full, and the best entry. One candidate is handled at a
// time, because the table has one read port and is scanned twice per candidate:
// once to find the worst and any equal score, once after the update to find the
// new worst and best. The result register lets the next transaction be accepted
// while a result waits. The capacity write channel is always ready and must only
// be used while the block is idle.
module best_k_score_keeper_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [47:0] s_tdata,   // score[31:0], tag[47:32]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [95:0] m_tdata,   // accepted[0], slot[4:1], equal_replaced[5],
                                 // entry_count[10:6], threshold_valid[11],
                                 // threshold[43:12], best_score[75:44],
                                 // best_tag[91:76], zero[95:92]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [4:0]  cfg_data   // capacity
);

  bksk_pkg::cmd_t    cmd;
  bksk_pkg::status_t status;

  assign cfg_ready = 1'b1;

  bksk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bksk_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

// ===== dv/best_k_score_keeper_checker.sv =====
// Checker for the score keeper: tracks the table, predicts each result and compares it.
`timescale 1ns / 1ps
module best_k_score_keeper_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire  [47:0] s_tdata,   // score[31:0], tag[47:32]
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire  [95:0] m_tdata,   // accepted[0], slot[4:1], equal_replaced[5],
                                 // entry_count[10:6], threshold_valid[11],
                                 // threshold[43:12], best_score[75:44],
                                 // best_tag[91:76], zero[95:92]
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire  [4:0]  cfg_data,  // capacity
  output int          mismatch_count,
  output int          outstanding,
  output int          accepted_seen,
  output int          equal_seen,
  output int          rejected_seen,
  output int          full_seen
);

  // declared from the top bit down so that accepted lands in bit 0
  typedef struct packed {
    logic [15:0]                  best_tag;
    logic [bksk_pkg::SCORE_W-1:0] best_score;
    logic [bksk_pkg::SCORE_W-1:0] threshold;
    logic                         threshold_valid;
    logic [4:0]                   entry_count;
    logic                         equal_replaced;
    logic [3:0]                   slot;
    logic                         accepted;
  } outcome_t;

  // shadow copy of the table
  logic [bksk_pkg::SCORE_W-1:0] kept_score [bksk_pkg::TABLE_DEPTH];
  logic [15:0]                  kept_tag   [bksk_pkg::TABLE_DEPTH];
  int                           kept_count;
  logic [bksk_pkg::CFG_W-1:0]   capacity;
  outcome_t                     outcome_q [$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
    accepted_seen  = 0;
    equal_seen     = 0;
    rejected_seen  = 0;
    full_seen      = 0;
    kept_count     = 0;
    capacity       = bksk_pkg::CFG_W'(bksk_pkg::CAP_RST);
  end

  function automatic int slots_in_use();
    if (capacity == 0) return 1;
    if (capacity > bksk_pkg::TABLE_DEPTH) return bksk_pkg::TABLE_DEPTH;
    return int'(capacity);
  endfunction

  // first slot holding the highest score among the first n
  function automatic int worst_slot(input int n);
    int pos;
    pos = 0;
    for (int j = 1; j < n; j++)
      if (kept_score[j] > kept_score[pos]) pos = j;
    return pos;
  endfunction

  function automatic outcome_t rank_candidate(input logic [bksk_pkg::SCORE_W-1:0] score,
                                              input logic [15:0] tag);
    outcome_t r;
    int       cap;
    int       n;
    int       pos;
    int       b;
    bit       acc;
    bit       eq;
    cap = slots_in_use();
    n   = (kept_count > cap) ? cap : kept_count;
    acc = 1'b1;
    eq  = 1'b0;
    if (n < cap) begin
      pos = n;
    end else begin
      pos = worst_slot(n);
      if (score > kept_score[pos]) acc = 1'b0;
    end
    if (acc) begin
      for (int j = 0; j < n; j++) begin
        if (kept_score[j] == score) begin
          pos = j;
          eq  = 1'b1;
          break;
        end
      end
      if (!eq && n < cap) n++;
      kept_score[pos] = score;
      kept_tag[pos]   = tag & ((17'd1 << bksk_pkg::TAG_BITS) - 1);
    end
    kept_count = n;

    r.accepted        = acc;
    r.slot            = acc ? 4'(pos) : 4'd0;
    r.equal_replaced  = eq;
    r.entry_count     = 5'(n);
    r.threshold_valid = (n == cap);
    r.threshold       = (n == cap) ? kept_score[worst_slot(n)] : '0;
    if (n > 0) begin
      b = 0;
      for (int j = 1; j < n; j++)
        if (kept_score[j] < kept_score[b]) b = j;
      r.best_score = kept_score[b];
      r.best_tag   = kept_tag[b];
    end else begin
      r.best_score = '0;
      r.best_tag   = '0;
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    outcome_t got;
    if (rst) begin
      kept_count = 0;
      capacity   = bksk_pkg::CFG_W'(bksk_pkg::CAP_RST);
      outcome_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[91:0];
        if (outcome_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with nothing pending, expected none, actual %h",
                   $time, m_tdata);
        end else begin
          want = outcome_q.pop_front();
          compare_field("accepted", want.accepted, got.accepted);
          compare_field("slot", want.slot, got.slot);
          compare_field("equal_replaced", want.equal_replaced, got.equal_replaced);
          compare_field("entry_count", want.entry_count, got.entry_count);
          compare_field("threshold_valid", want.threshold_valid, got.threshold_valid);
          compare_field("threshold", want.threshold, got.threshold);
          compare_field("best_score", want.best_score, got.best_score);
          compare_field("best_tag", want.best_tag, got.best_tag);
          compare_field("pad", 32'd0, m_tdata[95:92]);
          if (want.accepted) accepted_seen++;
          else rejected_seen++;
          if (want.equal_replaced) equal_seen++;
          if (want.threshold_valid) full_seen++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_data;
        if (kept_count > slots_in_use()) kept_count = slots_in_use();
      end
      if (s_tvalid && s_tready)
        outcome_q.push_back(rank_candidate(s_tdata[31:0], s_tdata[47:32]));
    end
    outstanding <= outcome_q.size();
  end

endmodule

// ===== dv/best_k_score_keeper_unit_tb.sv =====
// Testbench top for the score keeper: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module best_k_score_keeper_unit_tb;

  localparam int QUIET_LIMIT = 5000;   // cycles with no transaction at all
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // score[31:0], tag[47:32]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;        // accepted[0], slot[4:1], equal_replaced[5],
                               // entry_count[10:6], threshold_valid[11],
                               // threshold[43:12], best_score[75:44],
                               // best_tag[91:76], zero[95:92]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;  // capacity

  logic steady    = 1'b0;  // no idling on either side
  logic hold_off  = 1'b0;  // asks the receiver for one long stall
  int   quiet     = 0;
  int   sent      = 0;
  int   cfg_writes = 0;

  int mismatch_count;
  int outstanding;
  int accepted_seen;
  int equal_seen;
  int rejected_seen;
  int full_seen;

  best_k_score_keeper_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  best_k_score_keeper_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding),
    .accepted_seen (accepted_seen),
    .equal_seen    (equal_seen),
    .rejected_seen (rejected_seen),
    .full_seen     (full_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (steady || $urandom_range(0, 99) >= 17) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("[best_k_score_keeper_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic offer_candidate(input logic [31:0] score, input logic [15:0] tag);
    if (!steady) begin
      while ($urandom_range(0, 99) < 17) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {tag, score};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // capacity changes only once every result is back
  task automatic set_capacity(input logic [4:0] value);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin : stimulus
    logic [4:0]  caps [14] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd9, 5'd17,
                               5'd16, 5'd5, 5'd3, 5'd12, 5'd7, 5'd16, 5'd4};
    logic [31:0] falling;
    logic [31:0] score;
    int          pick;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // fill a small table, equal overwrite, equal-to-worst, replace, reject
    set_capacity(5'd4);
    offer_candidate(32'hFFFF_FFFF, 16'hFFFF);
    offer_candidate(32'h0000_0000, 16'h0000);
    offer_candidate(32'h0001_0000, 16'h1234);
    offer_candidate(32'h0001_0000, 16'hABCD);
    offer_candidate(32'h0000_0005, 16'h00FF);
    offer_candidate(32'hFFFF_FFFF, 16'h5555);
    offer_candidate(32'h0002_0000, 16'hAAAA);
    offer_candidate(32'hFFFF_FFFF, 16'h0F0F);
    offer_candidate(32'h0002_0000, 16'hF0F0);
    offer_candidate(32'h0000_0001, 16'h8001);
    // zero acts as one and cuts the count of a full table
    set_capacity(5'd0);
    offer_candidate(32'h0000_0007, 16'h0001);
    offer_candidate(32'h0000_0003, 16'h0002);
    offer_candidate(32'h0000_0003, 16'h0003);
    offer_candidate(32'hFFFF_FFFF, 16'h0004);
    // values above the built size act as the full table
    set_capacity(5'd31);
    offer_candidate(32'hAAAA_AAAA, 16'h5555);
    offer_candidate(32'h5555_5555, 16'hAAAA);
    offer_candidate(32'h0000_0000, 16'hFFFF);
    offer_candidate(32'h0000_0000, 16'h0000);
    offer_candidate(32'h8000_0000, 16'h8000);
    offer_candidate(32'h7FFF_FFFF, 16'h7FFF);
    set_capacity(5'd17);
    offer_candidate(32'h0000_FFFF, 16'hC3C3);
    offer_candidate(32'hFFFF_0000, 16'h3C3C);

    for (int ph = 0; ph < 14; ph++) begin
      set_capacity(caps[ph]);
      steady  <= (ph == 7);
      falling = 32'hFFFF_FFFF;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == 10) hold_off <= 1'b1;
        pick = $urandom_range(0, 99);
        // small pool gives frequent equal scores, falling run keeps
        // displacing the worst entry of a full table
        if (pick < 45) begin
          score = 32'($urandom_range(0, 40)) << 14;
        end else if (pick < 60) begin
          falling = falling - 32'($urandom_range(1, 1 << 24));
          score   = falling;
        end else if (pick < 85) begin
          score = $urandom;
        end else if (pick < 92) begin
          score = pick[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
        end else begin
          score = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
        end
        offer_candidate(score, 16'($urandom_range(0, 65535)));
      end
    end

    s_tvalid <= 1'b0;
    steady   <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (60) @(posedge clk);

    $display("Covered %0d candidates over %0d capacity writes (zero and oversize included):",
             sent, cfg_writes);
    $display("  %0d stored (%0d onto equal scores), %0d turned away, %0d with a full table",
             accepted_seen, equal_seen, rejected_seen, full_seen);
    if (mismatch_count == 0) begin
      $display("[best_k_score_keeper_unit] OK");
    end else begin
      $display("[best_k_score_keeper_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bksk_pkg.sv
rtl/core/bksk_ctrl.sv
rtl/core/bksk_datapath.sv
rtl/core/best_k_score_keeper_unit.sv
dv/best_k_score_keeper_checker.sv
dv/best_k_score_keeper_unit_tb.sv
